// ----- sv/brl_pkg.sv -----
// Shared constants, opcodes and controller/datapath interface types for the line rasterizer.
package brl_pkg;

  // Default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 32;

  // Field widths fixed by the request format
  localparam int OP_W    = 2;
  localparam int COORD_W = 9;
  localparam int BADDR_W = 9;
  localparam int DATA_W  = 8;
  localparam int CNT_W   = 8;
  // Bresenham error term: covers +/- (2*d + 2*run) for runs up to 511
  localparam int ERR_W   = 13;

  // Command opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted request
    logic sweep_en;  // zero one store byte, advance sweep pointer
    logic setup_a;   // pick major axis and ordered endpoints
    logic setup_b;   // deltas, step sign, initial error
    logic step;      // issue current pixel, advance the line walker
    logic rd_issue;  // present the read address to the store
    logic out_load;  // load the result register
  } brl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;  // sweep pointer on the final byte
    logic step_last;   // walker on the final pixel of the line
    logic pipe_busy;   // pixel read-modify-write still in flight
  } brl_status_t;

endpackage

// ----- sv/brl_ctrl.sv -----
// Controller state machine: sequences clear sweeps, line draws and byte reads.
module brl_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [brl_pkg::OP_W-1:0]  in_opcode,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  brl_pkg::brl_status_t      status,
  output brl_pkg::brl_cmd_t         cmd
);
  import brl_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_SETUP_A,
    S_SETUP_B,
    S_DRAW,
    S_DRAIN,
    S_READ,
    S_READ_WAIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Command decode and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_INIT: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_DRAW:  state_nxt = S_SETUP_A;
            OP_READ:  state_nxt = S_READ;
            default:  state_nxt = S_FINISH;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) state_nxt = S_FINISH;
      end
      S_SETUP_A: begin
        cmd.setup_a = 1'b1;
        state_nxt   = S_SETUP_B;
      end
      S_SETUP_B: begin
        cmd.setup_b = 1'b1;
        state_nxt   = S_DRAW;
      end
      S_DRAW: begin
        cmd.step = 1'b1;
        if (status.step_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.pipe_busy) state_nxt = S_FINISH;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/brl_datapath.sv -----
// Datapath: request registers, Bresenham walker, pixel read-modify-write pipe and frame store.
module brl_datapath #(
  parameter int SCREEN_WIDTH  = brl_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = brl_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [brl_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_end_y,
  input  logic [brl_pkg::BADDR_W-1:0]         in_byte_address,
  input  brl_pkg::brl_cmd_t                   cmd,
  output brl_pkg::brl_status_t                status,
  output logic [brl_pkg::DATA_W-1:0]          out_read_data,
  output logic [brl_pkg::CNT_W-1:0]           out_pixels_drawn
);
  import brl_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Captured request
  logic [OP_W-1:0]           op_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [BADDR_W-1:0]        baddr_r;

  // Line walker
  logic signed [COORD_W-1:0] a_r, a_end_r, b_r, b_end_r;
  logic                      major_y_r;
  logic                      s_neg_r;
  logic signed [ERR_W-1:0]   err_r, two_d_r, two_run_r;
  logic [CNT_W-1:0]          cnt_r;

  // Store, sweep pointer and RMW pipe
  logic [DATA_W-1:0] mem [STORE_BYTES];
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] p1_addr_r, p2_addr_r, lw_addr_r;
  logic [DATA_W-1:0] p1_mask_r, p2_mask_r, lw_data_r;
  logic              p1_v_r, p2_v_r, lw_v_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_ok_r;

  logic [DATA_W-1:0] out_rd_r;
  logic [CNT_W-1:0]  out_px_r;

  // Setup A: axis choice and endpoint ordering
  logic signed [COORD_W:0] dx, dy, adx, ady;
  logic                    pick_y, do_swap;
  // Setup B: deltas
  logic signed [COORD_W:0] run_w, db_w, d_w;
  // Step: current pixel
  logic signed [COORD_W-1:0] px, py;
  logic                      on_screen;
  logic                      err_pos;
  logic [ADDR_W-1:0]         pix_addr;
  logic [DATA_W-1:0]         wr_data;

  always_comb begin
    dx      = (COORD_W+1)'(x1_r) - (COORD_W+1)'(x0_r);
    dy      = (COORD_W+1)'(y1_r) - (COORD_W+1)'(y0_r);
    adx     = dx[COORD_W] ? -dx : dx;
    ady     = dy[COORD_W] ? -dy : dy;
    pick_y  = !(ady < adx);
    do_swap = pick_y ? (y0_r > y1_r) : (x0_r > x1_r);

    run_w = (COORD_W+1)'(a_end_r) - (COORD_W+1)'(a_r);
    db_w  = (COORD_W+1)'(b_end_r) - (COORD_W+1)'(b_r);
    d_w   = db_w[COORD_W] ? -db_w : db_w;

    px        = major_y_r ? b_r : a_r;
    py        = major_y_r ? a_r : b_r;
    on_screen = !px[COORD_W-1] && (int'(px) < SCREEN_WIDTH) &&
                !py[COORD_W-1] && (int'(py) < SCREEN_HEIGHT);
    pix_addr  = ADDR_W'(int'(py[COORD_W-1:3]) * SCREEN_WIDTH + int'(px));
    err_pos   = (err_r > 0);

    // merge with the byte written last cycle when it is the same byte
    wr_data = ((lw_v_r && (lw_addr_r == p2_addr_r)) ? lw_data_r : rd_data_r) | p2_mask_r;
  end

  // Request capture, walker setup and stepping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      x0_r    <= in_start_x;
      y0_r    <= in_start_y;
      x1_r    <= in_end_x;
      y1_r    <= in_end_y;
      baddr_r <= in_byte_address;
      cnt_r   <= '0;
    end
    if (cmd.setup_a) begin
      major_y_r <= pick_y;
      if (pick_y) begin
        a_r     <= do_swap ? y1_r : y0_r;
        a_end_r <= do_swap ? y0_r : y1_r;
        b_r     <= do_swap ? x1_r : x0_r;
        b_end_r <= do_swap ? x0_r : x1_r;
      end else begin
        a_r     <= do_swap ? x1_r : x0_r;
        a_end_r <= do_swap ? x0_r : x1_r;
        b_r     <= do_swap ? y1_r : y0_r;
        b_end_r <= do_swap ? y0_r : y1_r;
      end
    end
    if (cmd.setup_b) begin
      s_neg_r   <= db_w[COORD_W];
      two_d_r   <= ERR_W'(d_w) <<< 1;
      two_run_r <= ERR_W'(run_w) <<< 1;
      err_r     <= (ERR_W'(d_w) <<< 1) - ERR_W'(run_w);
    end
    if (cmd.step) begin
      a_r   <= a_r + COORD_W'(1);
      err_r <= err_r + two_d_r - (err_pos ? two_run_r : ERR_W'(0));
      if (err_pos) b_r <= s_neg_r ? b_r - COORD_W'(1) : b_r + COORD_W'(1);
      if (on_screen && (cnt_r != {CNT_W{1'b1}})) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Pixel pipe control and sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      lw_v_r    <= 1'b0;
    end else begin
      if (cmd.sweep_en) begin
        clr_cnt_r <= status.sweep_last ? '0 : clr_cnt_r + ADDR_W'(1);
      end
      p1_v_r <= cmd.step && on_screen;
      p2_v_r <= p1_v_r;
      lw_v_r <= p2_v_r;
    end
  end

  // Pipe payload: issue stage, read stage, last-write bypass
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      p1_addr_r <= pix_addr;
      p1_mask_r <= DATA_W'(1) << py[2:0];
    end else if (cmd.rd_issue) begin
      p1_addr_r <= ADDR_W'(baddr_r);
      rd_ok_r   <= (int'(baddr_r) < STORE_BYTES);
    end
    p2_addr_r <= p1_addr_r;
    p2_mask_r <= p1_mask_r;
    lw_addr_r <= p2_addr_r;
    lw_data_r <= wr_data;
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[p1_addr_r];
    if (cmd.sweep_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (p2_v_r) begin
      mem[p2_addr_r] <= wr_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rd_r <= ((op_r == OP_READ) && rd_ok_r) ? rd_data_r : '0;
      out_px_r <= (op_r == OP_DRAW) ? cnt_r : '0;
    end
  end

  assign status.sweep_last = (clr_cnt_r == ADDR_W'(STORE_BYTES - 1));
  assign status.step_last  = (a_r == a_end_r);
  assign status.pipe_busy  = p1_v_r || p2_v_r;
  assign out_read_data     = out_rd_r;
  assign out_pixels_drawn  = out_px_r;

endmodule

// ----- sv/bresenham_line_to_page_framebuffer_top.sv -----
// Per request: a read issues the address to the store and waits for its data; an unused opcode
// finishes at once; a clear zeroes SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes; a draw walks the
// major axis at one pixel per cycle, then the three-stage read-modify-write pipe drains.
// One request is in work at a time; out_valid rises in the same cycle that the next request can be
// taken, and a finished result waits while the output register is still held.
// Reset (rst_n, synchronous, active low) clears all 512 bytes by default, one byte per cycle.
module bresenham_line_to_page_framebuffer_top #(
  parameter int SCREEN_WIDTH  = brl_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = brl_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [brl_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [brl_pkg::COORD_W-1:0]  in_end_y,
  input  logic [brl_pkg::BADDR_W-1:0]         in_byte_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [brl_pkg::DATA_W-1:0]          out_read_data,
  output logic [brl_pkg::CNT_W-1:0]           out_pixels_drawn
);
  import brl_pkg::*;

  brl_cmd_t    cmd;
  brl_status_t status;

  brl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  brl_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_byte_address  (in_byte_address),
    .cmd              (cmd),
    .status           (status),
    .out_read_data    (out_read_data),
    .out_pixels_drawn (out_pixels_drawn)
  );

endmodule
